[sv/cpa_pkg.sv]
// Shared types and constants for the contiguous page allocator.
// Holds request and status codes, controller states and page geometry.
// No dependencies.
package cpa_pkg;

    localparam int unsigned PAGES_DEFAULT = 1024;
    localparam int unsigned PAGE_BYTES    = 4096;
    localparam int unsigned PAGE_LOG2     = $clog2(PAGE_BYTES);

    localparam logic [31:0] BASE_RESET = 32'h0040_0000;

    typedef enum logic [1:0] {
        REQ_ALLOC_PAGES = 2'd0,
        REQ_ALLOC_BYTES = 2'd1,
        REQ_FREE_RUN    = 2'd2,
        REQ_FREE_PAGE   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_BAD   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_LEN,
        S_WALK,
        S_DONE
    } state_t;

endpackage

[sv/cpa_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the page map. No dependencies.
module cpa_ram #(
    parameter int unsigned WIDTH = 11,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/contiguous_page_allocator_top.sv]
// Contiguous first-fit page allocator, top level.
// Depends on cpa_pkg and cpa_ram (page map storage).
//
// Usage:
//   Input channel (in_valid/in_stall) carries one request per beat: req_type,
//   amount (pages or bytes) and address (for frees). Output channel
//   (out_valid/out_stall) returns one beat per request: status,
//   result_address and page_count. cfg_we/cfg_wdata writes memory_base.
//   One request is in flight at a time; in_stall is low only while idle.
//   Steps from the accepting edge to out_valid (n = run pages):
//     allocate:    a first-fit map scan (one entry per cycle through the
//                  map RAM read port), then n entries marked, then the result.
//     free run:    read of the head entry, then one write per cleared entry.
//     free single: one entry cleared. Zero, oversize or out-of-map: result only.
//   The map RAM write port handles one entry per cycle; that sets the marking
//   and clearing time.
//   After reset the block clears the map (one entry per cycle)
//   with in_stall high; memory_base resets to 0x0040_0000.
//   A finished result sits in the output register while the next request is
//   accepted; if out_stall holds it there, the following result waits in
//   the controller until the register frees up.
module contiguous_page_allocator_top #(
    parameter int unsigned PAGES = cpa_pkg::PAGES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [31:0]                       cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  cpa_pkg::req_type_t                req_type,
    input  logic [22:0]                       amount,
    input  logic [31:0]                       address,
    output logic                              out_valid,
    input  logic                              out_stall,
    output cpa_pkg::status_t                  status,
    output logic [31:0]                       result_address,
    output logic [$clog2(PAGES+1)-1:0]        page_count
);

    import cpa_pkg::*;

    localparam int unsigned IW = $clog2(PAGES);
    localparam int unsigned CW = $clog2(PAGES + 1);
    localparam logic [CW-1:0] PAGES_C  = CW'(PAGES);
    localparam logic [23:0]   PAGES_24 = 24'(PAGES);
    localparam logic [31:0]   PAGES_32 = 32'(PAGES);

    state_t          state_reg, state_next;
    logic [31:0]     base_reg, base_next;
    logic [CW-1:0]   issue_reg, issue_next;
    logic            chk_valid_reg, chk_valid_next;
    logic [IW-1:0]   chk_idx_reg, chk_idx_next;
    logic [CW-1:0]   run_reg, run_next;
    logic [IW-1:0]   start_reg, start_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [IW-1:0]   wr_base_reg, wr_base_next;
    logic [CW-1:0]   wr_len_reg, wr_len_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic            mark_reg, mark_next;
    status_t         res_status_reg, res_status_next;
    logic [31:0]     res_addr_reg, res_addr_next;
    logic [CW-1:0]   res_count_reg, res_count_next;
    logic            out_valid_reg, out_valid_next;
    status_t         out_status_reg, out_status_next;
    logic [31:0]     out_addr_reg, out_addr_next;
    logic [CW-1:0]   out_count_reg, out_count_next;

    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    logic [CW-1:0]   ram_wdata;
    logic [IW-1:0]   ram_raddr;
    logic [CW-1:0]   ram_rdata;

    // request decode
    logic [23:0]     byte_sum;
    logic [23:0]     n_full;
    logic [31:0]     offset;
    logic [31:0]     page_no;
    logic            in_map;
    logic [IW-1:0]   idx_in;

    // scan and free helpers
    logic            issue_ok;
    logic [IW-1:0]   start_sel;
    logic [CW-1:0]   run_new;
    logic [CW-1:0]   remain;
    logic [CW-1:0]   free_len;

    cpa_ram #(
        .WIDTH (CW),
        .DEPTH (PAGES)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign byte_sum = {1'b0, amount} + 24'(PAGE_BYTES - 1);
    assign n_full   = (req_type == REQ_ALLOC_BYTES) ? (byte_sum >> PAGE_LOG2)
                                                    : {1'b0, amount};
    assign offset   = address - base_reg;
    assign page_no  = offset >> PAGE_LOG2;
    assign in_map   = (page_no < PAGES_32);
    assign idx_in   = page_no[IW-1:0];

    assign issue_ok  = (issue_reg < PAGES_C);
    assign start_sel = (run_reg == '0) ? chk_idx_reg : start_reg;
    assign run_new   = run_reg + CW'(1);
    assign remain    = PAGES_C - CW'(idx_reg);
    assign free_len  = (ram_rdata > remain) ? remain : ram_rdata;

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign result_address = out_addr_reg;
    assign page_count     = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        issue_next      = issue_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        run_next        = run_reg;
        start_next      = start_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        wr_base_next    = wr_base_reg;
        wr_len_next     = wr_len_reg;
        pos_next        = pos_reg;
        mark_next       = mark_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_count_next  = res_count_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_count_next  = out_count_reg;

        ram_we    = 1'b0;
        ram_waddr = wr_base_reg + pos_reg[IW-1:0];
        ram_wdata = '0;
        ram_raddr = idx_reg;

        if (cfg_we)
        begin
            base_next = cfg_wdata;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg[IW-1:0];
                pos_next  = pos_reg + CW'(1);
                if (pos_reg == PAGES_C - CW'(1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_addr_next  = '0;
                    res_count_next = '0;
                    case (req_type)
                        REQ_ALLOC_PAGES, REQ_ALLOC_BYTES:
                        begin
                            if (n_full == '0)
                            begin
                                res_status_next = ST_BAD;
                                state_next      = S_DONE;
                            end
                            else if (n_full > PAGES_24)
                            begin
                                res_status_next = ST_NOFIT;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                n_next         = n_full[CW-1:0];
                                issue_next     = '0;
                                chk_valid_next = 1'b0;
                                run_next       = '0;
                                state_next     = S_SCAN;
                            end
                        end
                        REQ_FREE_RUN:
                        begin
                            if (!in_map)
                            begin
                                res_status_next = ST_BAD;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                idx_next   = idx_in;
                                state_next = S_FREE_RD;
                            end
                        end
                        default:
                        begin
                            // free single page
                            if (!in_map)
                            begin
                                res_status_next = ST_BAD;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                wr_base_next    = idx_in;
                                wr_len_next     = CW'(1);
                                pos_next        = '0;
                                mark_next       = 1'b0;
                                res_status_next = ST_OK;
                                res_count_next  = CW'(1);
                                state_next      = S_WALK;
                            end
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // read one entry per cycle; ram_rdata belongs to chk_idx_reg
                ram_raddr      = issue_ok ? issue_reg[IW-1:0] : '0;
                chk_valid_next = issue_ok;
                chk_idx_next   = issue_reg[IW-1:0];
                if (issue_ok)
                begin
                    issue_next = issue_reg + CW'(1);
                end
                if (chk_valid_reg)
                begin
                    if (ram_rdata == '0)
                    begin
                        start_next = start_sel;
                        run_next   = run_new;
                        if (run_new == n_reg)
                        begin
                            wr_base_next    = start_sel;
                            wr_len_next     = n_reg;
                            pos_next        = '0;
                            mark_next       = 1'b1;
                            res_status_next = ST_OK;
                            res_addr_next   = base_reg + (32'(start_sel) << PAGE_LOG2);
                            res_count_next  = n_reg;
                            state_next      = S_WALK;
                        end
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
                else if (!issue_ok)
                begin
                    res_status_next = ST_NOFIT;
                    state_next      = S_DONE;
                end
            end

            S_FREE_RD:
            begin
                state_next = S_FREE_LEN;
            end

            S_FREE_LEN:
            begin
                res_status_next = ST_OK;
                res_count_next  = free_len;
                if (free_len == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    wr_base_next = idx_reg;
                    wr_len_next  = free_len;
                    pos_next     = '0;
                    mark_next    = 1'b0;
                    state_next   = S_WALK;
                end
            end

            S_WALK:
            begin
                // run head gets the length, the rest get 1; clears write 0
                ram_we = 1'b1;
                if (mark_reg)
                begin
                    ram_wdata = (pos_reg == '0) ? n_reg : CW'(1);
                end
                pos_next = pos_reg + CW'(1);
                if (pos_reg == wr_len_reg - CW'(1))
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    out_count_next  = res_count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            base_reg      <= BASE_RESET;
            pos_reg       <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            pos_reg       <= pos_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg      <= issue_next;
        chk_idx_reg    <= chk_idx_next;
        run_reg        <= run_next;
        start_reg      <= start_next;
        n_reg          <= n_next;
        idx_reg        <= idx_next;
        wr_base_reg    <= wr_base_next;
        wr_len_reg     <= wr_len_next;
        mark_reg       <= mark_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_count_reg  <= res_count_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_count_reg  <= out_count_next;
    end

    // the map is never written while a scan reads it
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !ram_we)
        else $error("map write during scan");

    // a partial run never reaches the request size without leaving the scan
    a_run_below_n: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (run_reg < n_reg))
        else $error("scan run overran request size");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (pos_reg < wr_len_reg && wr_len_reg != '0))
        else $error("walk position out of range");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_count_reg <= PAGES_C))
        else $error("page count exceeds map size");

    // failures never report an address or a page count
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK)
            |-> (out_addr_reg == '0 && out_count_reg == '0))
        else $error("failed request reported address or count");

endmodule
